// ===== hw/rtl/drc_pkg.sv =====
// Shared types and codes for the dirty rectangle coalescer.
// No dependencies; used by drc_cell and dirty_rect_set_coalescer.
package drc_pkg;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_COVERED = 3'd1,
    ST_DROPPED = 3'd2,
    ST_FLUSHED = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SQUEEZE,
    S_FLUSH
  } state_t;

  // per-cycle commands broadcast to every cell of the chain
  typedef struct packed {
    logic capture;  // latch the "contained by new rect" mark
    logic squeeze;  // close the gap at the first marked cell
    logic shift;    // flush: move whole chain one cell toward the head
    logic append;   // write the new rect into the first free cell
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/drc_cell.sv =====
// One storage cell of the rectangle chain: holds one rectangle and a kill mark,
// compares it against the incoming rectangle. Depends on drc_pkg.
module drc_cell #(
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  drc_pkg::cell_ctrl_t  ctrl,
  input  logic                 occupied,
  input  logic                 append_here,
  input  logic [3:0][CW-1:0]   cmp_rect,
  input  logic [3:0][CW-1:0]   new_rect,
  input  logic [3:0][CW-1:0]   next_rect,
  input  logic                 next_kill,
  input  logic                 kill_seen_in,
  output logic [3:0][CW-1:0]   rect_q,
  output logic                 kill_q,
  output logic                 covers,
  output logic                 contained,
  output logic                 kill_seen_out
);
  import drc_pkg::*;

  // coordinate order: 0 left, 1 top, 2 right, 3 bottom
  logic [3:0][CW-1:0] rect_r, rect_nxt;
  logic               kill_r, kill_nxt;
  logic signed [CW-1:0] sl, st, sr, sb, nl, nt, nr, nb;
  logic s_empty, n_empty, same, s_holds_n, n_holds_s;

  always_comb begin
    sl = $signed(rect_r[0]);
    st = $signed(rect_r[1]);
    sr = $signed(rect_r[2]);
    sb = $signed(rect_r[3]);
    nl = $signed(cmp_rect[0]);
    nt = $signed(cmp_rect[1]);
    nr = $signed(cmp_rect[2]);
    nb = $signed(cmp_rect[3]);
    s_empty   = (sr <= sl) || (sb <= st);
    n_empty   = (nr <= nl) || (nb <= nt);
    same      = (rect_r == cmp_rect);
    s_holds_n = !s_empty && !n_empty && (sl <= nl) && (st <= nt) && (sr >= nr) && (sb >= nb);
    n_holds_s = !s_empty && !n_empty && (nl <= sl) && (nt <= st) && (nr >= sr) && (nb >= sb);
  end

  assign covers        = occupied && (same || s_holds_n);
  assign contained     = occupied && n_holds_s;
  assign kill_seen_out = kill_seen_in || kill_r;
  assign rect_q        = rect_r;
  assign kill_q        = kill_r;

  always_comb begin
    rect_nxt = rect_r;
    kill_nxt = kill_r;
    if (ctrl.capture) begin
      kill_nxt = contained;
    end
    if (ctrl.squeeze && kill_seen_out) begin
      rect_nxt = next_rect;
      kill_nxt = next_kill;
    end
    if (ctrl.shift) begin
      rect_nxt = next_rect;
    end
    if (ctrl.append && append_here) begin
      rect_nxt = new_rect;
    end
  end

  always_ff @(posedge clk) begin
    rect_r <= rect_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kill_r <= 1'b0;
    end else begin
      kill_r <= kill_nxt;
    end
  end

endmodule

// ===== hw/rtl/dirty_rect_set_coalescer.sv =====
// Dirty rectangle coalescer: a chain of drc_cell storage cells plus the sequencer.
// Depends on drc_pkg and drc_cell.
//
// Timing: an item is taken at a clock edge where start is high and busy is low. Each
// result is registered: it shows on the out_ ports after the edge
// that ends its step, flagged by out_valid, and the receiver cannot stall it. An add
// that is covered by a stored rectangle is answered at the accept edge (all cells
// compare in parallel). Any other add latches the kill marks, then removes each
// stored rectangle it contains, since the chain closes one gap per cycle, then
// appends or drops the new one. A flush of a non-empty list shifts its head cell
// out each cycle, one result per rectangle; an empty flush is answered at accept.
module dirty_rect_set_coalescer #(
  parameter int MAX_RECTS  = 16,
  parameter int COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic signed [15:0] in_rect_left,
  input  logic signed [15:0] in_rect_top,
  input  logic signed [15:0] in_rect_right,
  input  logic signed [15:0] in_rect_bottom,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_top,
  output logic signed [15:0] out_right,
  output logic signed [15:0] out_bottom,
  output logic [4:0]         out_list_count,
  output logic               out_overflow_seen,
  output logic               out_last_of_run
);
  import drc_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int EW    = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int CNT_W = $clog2(MAX_RECTS + 1);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic                snap_r, snap_nxt;
  logic [3:0][CW-1:0]  nr_r, nr_nxt;
  cell_ctrl_t          ctrl;

  logic                ov_r, ov_nxt;
  status_t             ostat_r, ostat_nxt;
  logic [3:0][15:0]    orect_r, orect_nxt;
  logic [4:0]          ocnt_r, ocnt_nxt;
  logic                oovf_r, oovf_nxt;
  logic                olast_r, olast_nxt;

  logic [3:0][EW-1:0]  in_ext;
  logic [3:0][CW-1:0]  in_rect;
  logic [3:0][15:0]    head_rect;
  logic signed [EW-1:0] head_ext [4];

  logic [MAX_RECTS-1:0][3:0][CW-1:0] rect_q;
  logic [MAX_RECTS-1:0] kill_q, covers, contained, occ, app;
  logic [MAX_RECTS:0]   kill_chain;
  logic                 accept, any_cover, any_kill;

  // input fields are cut or zero-filled; head fields are sign-extended or cut
  always_comb begin
    in_ext[0] = EW'($unsigned(in_rect_left));
    in_ext[1] = EW'($unsigned(in_rect_top));
    in_ext[2] = EW'($unsigned(in_rect_right));
    in_ext[3] = EW'($unsigned(in_rect_bottom));
    for (int k = 0; k < 4; k++) begin
      in_rect[k]   = in_ext[k][CW-1:0];
      head_ext[k]  = EW'($signed(rect_q[0][k]));
      head_rect[k] = head_ext[k][15:0];
    end
  end

  assign kill_chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
    logic [3:0][CW-1:0] nb_rect;
    logic               nb_kill;
    if (i == MAX_RECTS - 1) begin : g_tail
      assign nb_rect = '0;
      assign nb_kill = 1'b0;
    end else begin : g_mid
      assign nb_rect = rect_q[i+1];
      assign nb_kill = kill_q[i+1];
    end
    assign occ[i] = (CNT_W'(i) < count_r);
    assign app[i] = (CNT_W'(i) == count_r);

    drc_cell #(.CW(CW)) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (ctrl),
      .occupied      (occ[i]),
      .append_here   (app[i]),
      .cmp_rect      (in_rect),
      .new_rect      (nr_r),
      .next_rect     (nb_rect),
      .next_kill     (nb_kill),
      .kill_seen_in  (kill_chain[i]),
      .rect_q        (rect_q[i]),
      .kill_q        (kill_q[i]),
      .covers        (covers[i]),
      .contained     (contained[i]),
      .kill_seen_out (kill_chain[i+1])
    );
  end

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign any_cover = |covers;
  assign any_kill  = |kill_q;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    snap_nxt  = snap_r;
    nr_nxt    = nr_r;
    ctrl      = '0;
    ov_nxt    = 1'b0;
    ostat_nxt = ostat_r;
    orect_nxt = '0;
    ocnt_nxt  = ocnt_r;
    oovf_nxt  = oovf_r;
    olast_nxt = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_FLUSH) begin
            ovf_nxt = 1'b0;
            if (count_r == '0) begin
              ov_nxt    = 1'b1;
              ostat_nxt = ST_EMPTY;
              ocnt_nxt  = '0;
              oovf_nxt  = ovf_r;
            end else begin
              snap_nxt  = ovf_r;
              state_nxt = S_FLUSH;
            end
          end else begin
            nr_nxt = in_rect;
            if (any_cover) begin
              ov_nxt    = 1'b1;
              ostat_nxt = ST_COVERED;
              ocnt_nxt  = 5'(count_r);
              oovf_nxt  = ovf_r;
            end else begin
              ctrl.capture = 1'b1;
              state_nxt    = S_SQUEEZE;
            end
          end
        end
      end
      S_SQUEEZE: begin
        if (any_kill) begin
          ctrl.squeeze = 1'b1;
          count_nxt    = count_r - 1'b1;
        end else if (count_r >= CNT_W'(MAX_RECTS)) begin
          ovf_nxt   = 1'b1;
          ov_nxt    = 1'b1;
          ostat_nxt = ST_DROPPED;
          ocnt_nxt  = 5'(count_r);
          oovf_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ctrl.append = 1'b1;
          count_nxt   = count_r + 1'b1;
          ov_nxt      = 1'b1;
          ostat_nxt   = ST_ADDED;
          ocnt_nxt    = 5'(count_r + 1'b1);
          oovf_nxt    = ovf_r;
          state_nxt   = S_IDLE;
        end
      end
      S_FLUSH: begin
        ctrl.shift = 1'b1;
        count_nxt  = count_r - 1'b1;
        ov_nxt     = 1'b1;
        ostat_nxt  = ST_FLUSHED;
        orect_nxt  = head_rect;
        ocnt_nxt   = '0;
        oovf_nxt   = snap_r;
        olast_nxt  = (count_r == CNT_W'(1));
        if (count_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r  <= snap_nxt;
    nr_r    <= nr_nxt;
    ostat_r <= ostat_nxt;
    orect_r <= orect_nxt;
    ocnt_r  <= ocnt_nxt;
    oovf_r  <= oovf_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid         = ov_r;
  assign out_status        = ostat_r;
  assign out_left          = $signed(orect_r[0]);
  assign out_top           = $signed(orect_r[1]);
  assign out_right         = $signed(orect_r[2]);
  assign out_bottom        = $signed(orect_r[3]);
  assign out_list_count    = ocnt_r;
  assign out_overflow_seen = oovf_r;
  assign out_last_of_run   = olast_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RECTS))
    else $error("stored count above capacity");

  a_add_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == OP_ADD) |=> (ov_r || state_r == S_SQUEEZE))
    else $error("add neither answered nor squeezing");

  a_squeeze_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQUEEZE && any_kill) |=> (count_r == $past(count_r) - 1'b1))
    else $error("squeeze did not drop one entry");

  a_flush_end: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ostat_r == ST_FLUSHED && olast_r) |-> (count_r == '0 && state_r == S_IDLE))
    else $error("flush ended with entries left");

endmodule
